// ===== rtl/amrb_pkg.sv =====
// Package for the audio mixing ring buffer: ring geometry, operation and
// register codes, shared types and the Q4.12 truncate-and-saturate function.
// Depends on nothing; amrb_regs, amrb_core and the top level use it.
`default_nettype none
package amrb_pkg;

	// Ring depth must be a power of two; indices wrap by dropping upper bits.
	localparam int RING_DEPTH = 65536;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

	localparam logic [1:0] OP_CONSUME = 2'd0;
	localparam logic [1:0] OP_MIX     = 2'd1;
	localparam logic [1:0] OP_WRITE   = 2'd2;

	localparam logic [1:0] REG_MASTER_GAIN  = 2'd0;
	localparam logic [1:0] REG_MUSIC_GAIN   = 2'd1;
	localparam logic [1:0] REG_EFFECTS_GAIN = 2'd2;

	localparam logic [15:0] MASTER_GAIN_RST  = 16'd328;
	localparam logic [15:0] MUSIC_GAIN_RST   = 16'd4096;
	localparam logic [15:0] EFFECTS_GAIN_RST = 16'd4096;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WORK
	} state_t;

	typedef struct packed {
		logic [15:0] master;
		logic [15:0] music;
		logic [15:0] effects;
	} gains_t;

	typedef struct packed {
		logic               we;
		logic               re;
		logic [RING_AW-1:0] addr;
		logic [15:0]        wdata;
	} mem_req_t;

	function automatic logic [RING_AW-1:0] pos_to_idx(input logic [15:0] p);
		logic [RING_AW+15:0] w;
		w = {{RING_AW{1'b0}}, p};
		return w[RING_AW-1:0];
	endfunction

	// Divide by 4096 truncating toward zero, then clamp to 16 bits.
	function automatic logic signed [15:0] sat_q12(input logic signed [33:0] v);
		logic signed [33:0] t;
		t = (v < 0) ? ((v + 34'sd4095) >>> 12) : (v >>> 12);
		if (t > 34'sd32767) begin
			return 16'sh7fff;
		end else if (t < -34'sd32768) begin
			return -16'sh8000;
		end
		return t[15:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/amrb_item_if.sv =====
// Request channel of the audio mixing ring buffer: valid/ready plus fields.
// Depends on nothing.
`default_nettype none
interface amrb_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [15:0] sample;
	logic [15:0]        position;
	logic [15:0]        mix_gain;
	logic               music_sel;
	logic               burst_last;

	modport source (output valid, operation, sample, position, mix_gain, music_sel,
		burst_last, input ready);
	modport sink (input valid, operation, sample, position, mix_gain, music_sel,
		burst_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/amrb_result_if.sv =====
// Result channel of the audio mixing ring buffer: valid/ready plus fields.
// Depends on nothing.
`default_nettype none
interface amrb_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] out_sample;
	logic               burst_end;

	modport source (output valid, out_sample, burst_end, input ready);
	modport sink (input valid, out_sample, burst_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/amrb_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// Depends on nothing.
`default_nettype none
module amrb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/amrb_regs.sv =====
// APB-style configuration registers holding the three Q4.12 gains.
// Depends on amrb_pkg.
`default_nettype none
module amrb_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output amrb_pkg::gains_t       gains
);

	amrb_pkg::gains_t gains_q;
	logic             wr_en;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign gains   = gains_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.master  <= amrb_pkg::MASTER_GAIN_RST;
			gains_q.music   <= amrb_pkg::MUSIC_GAIN_RST;
			gains_q.effects <= amrb_pkg::EFFECTS_GAIN_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				amrb_pkg::REG_MASTER_GAIN:  gains_q.master  <= pwdata[15:0];
				amrb_pkg::REG_MUSIC_GAIN:   gains_q.music   <= pwdata[15:0];
				amrb_pkg::REG_EFFECTS_GAIN: gains_q.effects <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			amrb_pkg::REG_MASTER_GAIN:  prdata = {16'd0, gains_q.master};
			amrb_pkg::REG_MUSIC_GAIN:   prdata = {16'd0, gains_q.music};
			amrb_pkg::REG_EFFECTS_GAIN: prdata = {16'd0, gains_q.effects};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/amrb_core.sv =====
// Sequencer and datapath of the ring buffer: clearing pass, read of the ring
// entry, scale and saturate, write-back, play cursor and result register.
// Depends on amrb_pkg, amrb_item_if and amrb_result_if.
`default_nettype none
module amrb_core (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire amrb_pkg::gains_t        gains,
	amrb_item_if.sink                    item,
	amrb_result_if.source                result,
	output amrb_pkg::mem_req_t           mem_req,
	input  wire logic [15:0]             mem_rdata
);

	amrb_pkg::state_t state_q, state_d;

	logic [amrb_pkg::RING_AW-1:0] clr_addr_q;
	logic [amrb_pkg::RING_AW-1:0] play_q;
	logic [amrb_pkg::RING_AW-1:0] idx_in;
	logic [amrb_pkg::RING_AW-1:0] idx_s1;
	logic [1:0]                   op_s1;
	logic signed [32:0]           prod_s1;
	logic                         last_s1;
	logic                         out_valid_q;
	logic signed [15:0]           out_sample_q;
	logic                         out_last_q;

	logic [15:0]        gain_sel;
	logic signed [16:0] gain_in;
	logic signed [32:0] prod_in;
	logic signed [15:0] entry;
	logic signed [16:0] master_ext;
	logic signed [32:0] cons_prod;
	logic signed [33:0] mix_sum;
	logic signed [15:0] cons_val;
	logic signed [15:0] mix_val;
	logic signed [15:0] write_val;
	logic               accept;
	logic               stall;
	logic               work_done;
	logic               load_out;

	assign accept = item.valid & item.ready;
	assign stall  = out_valid_q & ~result.ready;

	always_comb begin
		gain_sel = (item.operation == amrb_pkg::OP_MIX) ? item.mix_gain :
			(item.music_sel ? gains.music : gains.effects);
		gain_in = signed'({1'b0, gain_sel});
		prod_in = item.sample * gain_in;
		case (item.operation)
			amrb_pkg::OP_MIX:   idx_in = play_q + amrb_pkg::pos_to_idx(item.position);
			amrb_pkg::OP_WRITE: idx_in = amrb_pkg::pos_to_idx(item.position);
			default:            idx_in = play_q;
		endcase
	end

	always_comb begin
		entry      = signed'(mem_rdata);
		master_ext = signed'({1'b0, gains.master});
		cons_prod  = entry * master_ext;
		mix_sum    = 34'(prod_s1) + (34'(entry) <<< 12);
		cons_val   = amrb_pkg::sat_q12(34'(cons_prod));
		mix_val    = amrb_pkg::sat_q12(mix_sum);
		write_val  = amrb_pkg::sat_q12(34'(prod_s1));
	end

	assign work_done = (state_q == amrb_pkg::ST_WORK) &&
		!((op_s1 == amrb_pkg::OP_CONSUME) && stall);
	assign load_out  = work_done && (op_s1 == amrb_pkg::OP_CONSUME);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			amrb_pkg::ST_CLEAR: begin
				if (clr_addr_q == amrb_pkg::RING_LAST) begin
					state_d = amrb_pkg::ST_IDLE;
				end
			end
			amrb_pkg::ST_IDLE: begin
				if (item.valid) begin
					state_d = amrb_pkg::ST_WORK;
				end
			end
			amrb_pkg::ST_WORK: begin
				if (work_done) begin
					state_d = amrb_pkg::ST_IDLE;
				end
			end
			default: state_d = amrb_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		item.ready    = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.addr  = idx_s1;
		mem_req.wdata = 16'd0;
		unique case (state_q)
			amrb_pkg::ST_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_addr_q;
			end
			amrb_pkg::ST_IDLE: begin
				item.ready   = 1'b1;
				mem_req.re   = item.valid;
				mem_req.addr = idx_in;
			end
			amrb_pkg::ST_WORK: begin
				case (op_s1)
					amrb_pkg::OP_CONSUME: begin
						mem_req.we    = work_done;
						mem_req.wdata = 16'd0;
					end
					amrb_pkg::OP_MIX: begin
						mem_req.we    = work_done;
						mem_req.wdata = mix_val;
					end
					amrb_pkg::OP_WRITE: begin
						mem_req.we    = work_done;
						mem_req.wdata = write_val;
					end
					default: mem_req.we = 1'b0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= amrb_pkg::ST_CLEAR;
			clr_addr_q  <= '0;
			play_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == amrb_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (load_out) begin
				play_q <= idx_s1 + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= item.operation;
			idx_s1  <= idx_in;
			prod_s1 <= prod_in;
			last_s1 <= item.burst_last;
		end
		if (load_out) begin
			out_sample_q <= cons_val;
			out_last_q   <= last_s1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_sample = out_sample_q;
	assign result.burst_end  = out_last_q;

`ifndef SYNTH
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == amrb_pkg::ST_CLEAR) |-> !item.ready)
		else $error("Request accepted during the clearing pass.");

	a_result_from_consume: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(op_s1 == amrb_pkg::OP_CONSUME))
		else $error("Result produced by an operation other than consume.");

	a_cursor_moves_on_consume: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(play_q) |-> $past(load_out))
		else $error("Play cursor moved without a consume.");

	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && accept))
		else $error("Ring write overlaps a request acceptance.");
`endif

endmodule
`default_nettype wire

// ===== rtl/audio_mix_ring_buffer.sv =====
// Top level of the audio mixing ring buffer: configuration registers, ring
// memory and sequencer. Depends on amrb_pkg, amrb_item_if, amrb_result_if,
// amrb_ram, amrb_regs and amrb_core.
//
//   Channel  Kind           Fields
//   item     valid/ready in operation, sample, position, mix_gain, music_sel,
//                           burst_last
//   result   valid/ready out out_sample, burst_end
//   APB      write/read     master_gain @0x0, music_gain @0x4, effects_gain @0x8
//
// Each request is handled in order: the ring entry is read from the single-port
// RAM, then the new value is computed, saturated and written back. No new request is taken until then.
// After reset a clearing pass writes zero to all RING_DEPTH (65536) entries
// before the first request is taken; configuration writes are taken.
// A consume holds in its write-back cycle while the result register is full and result.ready is low.
`default_nettype none
module audio_mix_ring_buffer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	amrb_item_if.sink        item,
	amrb_result_if.source    result
);

	amrb_pkg::gains_t   gains;
	amrb_pkg::mem_req_t mem_req;
	logic [15:0]        mem_rdata;

	amrb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	amrb_ram #(
		.WIDTH (16),
		.DEPTH (amrb_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (mem_rdata)
	);

	amrb_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains),
		.item      (item),
		.result    (result),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

endmodule
`default_nettype wire
